### hdl/hns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hns_pkg;

  typedef struct packed {
    logic        func;
    logic [19:0] key;
    logic [5:0]  query_slot;
  } in_t;

  typedef struct packed {
    logic [5:0] neighbor_slot;
    logic       found;
    logic       last;
    logic [1:0] status;
  } out_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_BAD_SLOT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic load;
    logic bad_query;
    logic query_start;
    logic capture;
    logic pass_start;
    logic promote;
    logic emit_mid;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic qs_bad;
    logic pass_done;
    logic best_found;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### hdl/hamming_neighbor_search.sv
// load or rejected query: result in the output register the next cycle
// query: each scan pass reads every loaded slot once from the key table, one per cycle;
// a query takes (hits + 1) passes
// the next item is taken once the previous one has been fully issued
// synchronous active-high reset empties the table and returns to idle
`timescale 1ns / 1ps
`default_nettype none
module hamming_neighbor_search #(
  parameter int KEY_BITS  = 20,
  parameter int MAX_SLOTS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire hns_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output hns_pkg::out_t      out_data
);

  hns_pkg::cmd_t  cmd;
  hns_pkg::stat_t stat;

  hns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (in_data.func),
    .stat     (stat),
    .cmd      (cmd)
  );

  hns_datapath #(
    .KEY_BITS  (KEY_BITS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire

### hdl/hns_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module hns_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           func,
  input  wire hns_pkg::stat_t stat,
  output hns_pkg::cmd_t       cmd
);

  hns_pkg::state_t state;
  hns_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      hns_pkg::ST_IDLE: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          if (func == hns_pkg::FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else if (stat.qs_bad) begin
            cmd.bad_query = 1'b1;
          end else begin
            cmd.query_start = 1'b1;
            state_next      = hns_pkg::ST_CENTRE;
          end
        end
      end
      hns_pkg::ST_CENTRE: begin
        cmd.capture    = 1'b1;
        cmd.pass_start = 1'b1;
        state_next     = hns_pkg::ST_SCAN;
      end
      hns_pkg::ST_SCAN: begin
        if (stat.pass_done) begin
          state_next = hns_pkg::ST_DECIDE;
        end
      end
      hns_pkg::ST_DECIDE: begin
        if (stat.best_found) begin
          if (!stat.pend_valid) begin
            cmd.promote    = 1'b1;
            cmd.pass_start = 1'b1;
            state_next     = hns_pkg::ST_SCAN;
          end else if (stat.out_free) begin
            cmd.emit_mid   = 1'b1;
            cmd.promote    = 1'b1;
            cmd.pass_start = 1'b1;
            state_next     = hns_pkg::ST_SCAN;
          end
        end else if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = hns_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hns_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/hns_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module hns_datapath #(
  parameter int KEY_BITS  = 20,
  parameter int MAX_SLOTS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire hns_pkg::in_t   in_data,
  input  wire hns_pkg::cmd_t  cmd,
  output hns_pkg::stat_t      stat,
  output hns_pkg::out_t       out_data,
  output logic                out_valid,
  input  wire logic           out_stall
);

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int IW = $clog2(KEY_BITS);
  localparam int OW = 1 + 2 * IW;

  function automatic logic [IW-1:0] low_idx(input logic [KEY_BITS-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int b = KEY_BITS - 1; b >= 0; b--) begin
      if (v[b]) r = IW'(b);
    end
    return r;
  endfunction

  function automatic logic [IW-1:0] high_idx(input logic [KEY_BITS-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int b = 0; b < KEY_BITS; b++) begin
      if (v[b]) r = IW'(b);
    end
    return r;
  endfunction

  logic [KEY_BITS-1:0] keys [MAX_SLOTS];
  logic [KEY_BITS-1:0] rdata;
  logic [SW-1:0]       raddr;
  logic [CW-1:0]       count;
  logic [KEY_BITS-1:0] centre;

  logic                scanning;
  logic [CW-1:0]       scan_cnt;
  logic                rd_v;
  logic [SW-1:0]       rd_slot;
  logic                ord_v;
  logic [OW-1:0]       ord;
  logic [SW-1:0]       ord_slot;
  logic                best_found;
  logic [OW-1:0]       best_ord;
  logic [SW-1:0]       best_slot;
  logic                have_last;
  logic [OW-1:0]       last_ord;
  logic                pend_valid;
  logic [SW-1:0]       pend_slot;

  logic                full;
  logic                out_free;
  logic [KEY_BITS-1:0] diff;
  logic [KEY_BITS-1:0] diff_low;
  logic                dist_one;
  logic                dist_two;
  logic [OW-1:0]       ord_c;
  logic                take;

  assign full     = (count == CW'(MAX_SLOTS));
  assign out_free = !out_valid || !out_stall;

  assign diff     = rdata ^ centre;
  assign diff_low = diff & (diff - KEY_BITS'(1));
  assign dist_one = (diff != '0) && (diff_low == '0);
  assign dist_two = (diff_low != '0) && ((diff_low & (diff_low - KEY_BITS'(1))) == '0);
  assign ord_c    = {dist_two, ~low_idx(diff), dist_two ? ~high_idx(diff) : {IW{1'b0}}};

  assign take = ord_v && (!have_last || ord > last_ord) && (!best_found || ord <= best_ord);

  always_comb begin
    if (scanning) begin
      raddr = scan_cnt[SW-1:0];
    end else begin
      raddr = in_data.query_slot[SW-1:0];
    end
  end

  assign stat.qs_bad     = 7'(in_data.query_slot) >= 7'(count);
  assign stat.pass_done  = !scanning && !rd_v && !ord_v;
  assign stat.best_found = best_found;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  // key table
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      keys[count[SW-1:0]] <= KEY_BITS'(in_data.key);
    end
    rdata <= keys[raddr];
  end

  // scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      scanning   <= 1'b0;
      rd_v       <= 1'b0;
      ord_v      <= 1'b0;
      best_found <= 1'b0;
      have_last  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.load && !full) begin
        count <= count + CW'(1);
      end
      rd_v  <= scanning;
      ord_v <= rd_v && (dist_one || dist_two);
      if (take) begin
        best_found <= 1'b1;
      end
      if (scanning && (scan_cnt + CW'(1) == count)) begin
        scanning <= 1'b0;
      end
      if (cmd.capture) begin
        have_last  <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (cmd.promote) begin
        have_last  <= 1'b1;
        pend_valid <= 1'b1;
      end
      if (cmd.emit_final) begin
        pend_valid <= 1'b0;
      end
      if (cmd.pass_start) begin
        scanning   <= 1'b1;
        best_found <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      centre <= rdata;
    end
    if (cmd.pass_start) begin
      scan_cnt <= '0;
    end else if (scanning) begin
      scan_cnt <= scan_cnt + CW'(1);
    end
    rd_slot  <= scan_cnt[SW-1:0];
    ord      <= ord_c;
    ord_slot <= rd_slot;
    if (take) begin
      best_ord  <= ord;
      best_slot <= ord_slot;
    end
    if (cmd.promote) begin
      last_ord  <= best_ord;
      pend_slot <= best_slot;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load || cmd.bad_query || cmd.emit_mid || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= '{neighbor_slot: '0, found: 1'b0, last: 1'b1,
                    status: full ? hns_pkg::STATUS_FULL : hns_pkg::STATUS_OK};
    end else if (cmd.bad_query) begin
      out_data <= '{neighbor_slot: '0, found: 1'b0, last: 1'b1,
                    status: hns_pkg::STATUS_BAD_SLOT};
    end else if (cmd.emit_mid) begin
      out_data <= '{neighbor_slot: 6'(pend_slot), found: 1'b1, last: 1'b0,
                    status: hns_pkg::STATUS_OK};
    end else if (cmd.emit_final) begin
      out_data <= '{neighbor_slot: pend_valid ? 6'(pend_slot) : 6'd0, found: pend_valid,
                    last: 1'b1, status: hns_pkg::STATUS_OK};
    end
  end

endmodule
`default_nettype wire
